// ===== rtl/core/fcr_pkg.sv =====
// shared types, constants and helpers for the fan curve block
`default_nettype none

package fcr_pkg;

	localparam int unsigned BYTE_W        = 8;
	localparam int unsigned SLOT_CNT      = 8;
	localparam int unsigned SLOT_IDX_W    = 3;
	localparam int unsigned PACK_W        = BYTE_W * SLOT_CNT;
	localparam int unsigned COUNT_W       = 4;
	localparam int unsigned CFG_IDX_W     = 2;
	localparam int unsigned CFG_DATA_W    = PACK_W;
	localparam int unsigned IN_DATA_W     = 8;
	localparam int unsigned OUT_DATA_W    = 16;
	localparam int unsigned ACC_W         = 2 * BYTE_W + 1;
	localparam int unsigned DEF_MAX_POINTS = 8;

	localparam logic [COUNT_W-1:0] POINT_COUNT_RST = 4'd2;
	localparam logic [BYTE_W-1:0]  RAMP_STEP_RST   = 8'd255;
	localparam logic [BYTE_W-1:0]  DUTY_RST        = 8'd255;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_POINT_COUNT = 2'd0,
		REG_TEMP_POINTS = 2'd1,
		REG_DUTY_POINTS = 2'd2,
		REG_RAMP_STEP   = 2'd3
	} fcr_reg_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MUL,
		ST_DIV,
		ST_RAMP
	} fcr_state_t;

	function automatic logic [BYTE_W-1:0] byte_at(input logic [PACK_W-1:0] packed_v,
		input logic [SLOT_IDX_W-1:0] idx);
		logic [PACK_W-1:0] sh;
		sh = packed_v >> {idx, 3'b000};
		return sh[BYTE_W-1:0];
	endfunction

endpackage

`default_nettype wire

// ===== rtl/core/fan_curve_with_pwm_ramp.sv =====
// fan curve lookup with serial interpolation and duty slew limiting
`default_nettype none

// Each temperature sample on the s_ side yields one result on the m_ side: the duty read
// off a piecewise-linear curve of up to MAX_POINTS points (target_duty), the duty after
// the ramp limit (duty_out) and a flag that the duty moved (duty_changed, on m_tuser).
// Samples outside the curve or on a clamped segment go from IDLE straight to RAMP;
// samples between two points pass through a bit-serial multiply-accumulate (MUL)
// and then a restoring divider giving one quotient bit per cycle (DIV) before RAMP.
// One sample is in work at a time; a finished result waits in the output register while
// the next sample is taken. Duty resets to full speed (255).
// Configuration writes are accepted at any time but are meant for an idle block.
module fan_curve_with_pwm_ramp #(
	parameter int unsigned MAX_POINTS = fcr_pkg::DEF_MAX_POINTS
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	// configuration write channel
	input  wire logic                            cfg_valid,
	output logic                                 cfg_ready,
	input  wire logic [fcr_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [fcr_pkg::CFG_DATA_W-1:0]  cfg_data,
	// sample input
	input  wire logic                            s_tvalid,
	output logic                                 s_tready,
	input  wire logic [fcr_pkg::IN_DATA_W-1:0]   s_tdata,   // [7:0] temperature
	// result output
	output logic                                 m_tvalid,
	input  wire logic                            m_tready,
	output logic [fcr_pkg::OUT_DATA_W-1:0]       m_tdata,   // [7:0] duty_out, [15:8] target_duty
	output logic                                 m_tuser    // [0] duty_changed
);

	import fcr_pkg::*;

	// configuration registers
	logic [COUNT_W-1:0] point_count_q;
	logic [PACK_W-1:0]  temp_points_q;
	logic [PACK_W-1:0]  duty_points_q;
	logic [BYTE_W-1:0]  ramp_step_q;

	// control
	fcr_state_t         state_q, state_nxt;
	logic [2:0]         cnt_q;
	logic               out_valid_q;
	logic               accept;
	logic               out_load;

	// datapath
	logic [BYTE_W-1:0]  present_q;
	logic [BYTE_W-1:0]  target_q;
	logic [BYTE_W-1:0]  lo_d_q, hi_d_q;
	logic [BYTE_W-1:0]  wa_q, wb_q;
	logic [BYTE_W-1:0]  span_q;
	logic [ACC_W-1:0]   acc_q;
	logic [ACC_W-1:0]   div_q;
	logic [BYTE_W-1:0]  duty_out_q, target_out_q;
	logic               changed_q;

	// curve lookup on the incoming sample
	logic [COUNT_W-1:0]    n_eff;
	logic [SLOT_IDX_W-1:0] last_idx;
	logic [SLOT_IDX_W-1:0] seg_idx;
	logic [SLOT_IDX_W-1:0] hi_idx;
	logic                  seg_found;
	logic [BYTE_W-1:0]     t_in, lo_t, hi_t, lo_d, hi_d;
	logic                  direct;
	logic [BYTE_W-1:0]     direct_duty;

	always_comb begin
		if (point_count_q < 4'd2) begin
			n_eff = 4'd2;
		end else if (point_count_q > COUNT_W'(MAX_POINTS)) begin
			n_eff = COUNT_W'(MAX_POINTS);
		end else begin
			n_eff = point_count_q;
		end
		last_idx = SLOT_IDX_W'(n_eff - 4'd1);
		t_in     = s_tdata[BYTE_W-1:0];
		seg_found = 1'b0;
		seg_idx   = '0;
		// highest segment start at or below the sample wins
		for (int k = 0; k < int'(MAX_POINTS) - 1; k++) begin
			if (COUNT_W'(k) <= n_eff - 4'd2
			    && t_in >= byte_at(temp_points_q, SLOT_IDX_W'(k))) begin
				seg_found = 1'b1;
				seg_idx   = SLOT_IDX_W'(k);
			end
		end
		hi_idx = seg_idx + 3'd1;
		lo_t   = byte_at(temp_points_q, seg_idx);
		hi_t   = byte_at(temp_points_q, hi_idx);
		lo_d   = byte_at(duty_points_q, seg_idx);
		hi_d   = byte_at(duty_points_q, hi_idx);
		if (t_in >= byte_at(temp_points_q, last_idx)) begin
			direct      = 1'b1;
			direct_duty = byte_at(duty_points_q, last_idx);
		end else if (!seg_found) begin
			direct      = 1'b1;
			direct_duty = byte_at(duty_points_q, '0);
		end else if (hi_t <= t_in) begin
			// only reachable with out-of-order curve temperatures
			direct      = 1'b1;
			direct_duty = hi_d;
		end else begin
			direct      = 1'b0;
			direct_duty = '0;
		end
	end

	// serial multiply-accumulate step, msb first on both weights
	logic [ACC_W-1:0] mul_nxt;
	logic [ACC_W-1:0] num_full;
	logic             div_ge;

	always_comb begin
		mul_nxt = {acc_q[ACC_W-2:0], 1'b0}
		        + (wa_q[BYTE_W-1] ? ACC_W'(lo_d_q) : '0)
		        + (wb_q[BYTE_W-1] ? ACC_W'(hi_d_q) : '0);
		// numerator for round half up: 2*sum + span
		num_full = {mul_nxt[ACC_W-2:0], 1'b0} + ACC_W'(span_q);
		div_ge   = acc_q >= div_q;
	end

	// slew limit
	logic [BYTE_W-1:0] step_eff;
	logic [BYTE_W:0]   up_sum;
	logic [BYTE_W-1:0] duty_nxt;

	always_comb begin
		step_eff = (ramp_step_q == '0) ? 8'd1 : ramp_step_q;
		up_sum   = {1'b0, present_q} + {1'b0, step_eff};
		if (present_q < target_q) begin
			duty_nxt = (up_sum > {1'b0, target_q}) ? target_q : up_sum[BYTE_W-1:0];
		end else if (present_q > target_q) begin
			if (present_q >= step_eff && (present_q - step_eff) >= target_q) begin
				duty_nxt = present_q - step_eff;
			end else begin
				duty_nxt = target_q;
			end
		end else begin
			duty_nxt = present_q;
		end
	end

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					state_nxt = direct ? ST_RAMP : ST_MUL;
				end
			end
			ST_MUL: begin
				if (cnt_q == 3'd7) begin
					state_nxt = ST_DIV;
				end
			end
			ST_DIV: begin
				if (cnt_q == 3'd7) begin
					state_nxt = ST_RAMP;
				end
			end
			ST_RAMP: begin
				if (!out_valid_q || m_tready) begin
					state_nxt = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	// control outputs
	always_comb begin
		s_tready = 1'b0;
		out_load = 1'b0;
		case (state_q)
			ST_IDLE: s_tready = 1'b1;
			ST_RAMP: out_load = !out_valid_q || m_tready;
			default: begin
				s_tready = 1'b0;
				out_load = 1'b0;
			end
		endcase
	end

	assign accept    = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			point_count_q <= POINT_COUNT_RST;
			temp_points_q <= '0;
			duty_points_q <= '0;
			ramp_step_q   <= RAMP_STEP_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_POINT_COUNT: point_count_q <= cfg_data[COUNT_W-1:0];
				REG_TEMP_POINTS: temp_points_q <= cfg_data;
				REG_DUTY_POINTS: duty_points_q <= cfg_data;
				REG_RAMP_STEP:   ramp_step_q   <= cfg_data[BYTE_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
			present_q   <= DUTY_RST;
		end else begin
			state_q <= state_nxt;
			if (state_q != state_nxt) begin
				cnt_q <= '0;
			end else begin
				cnt_q <= cnt_q + 3'd1;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
				present_q   <= duty_nxt;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			target_q <= direct_duty;
			lo_d_q   <= lo_d;
			hi_d_q   <= hi_d;
			wa_q     <= hi_t - t_in;
			wb_q     <= t_in - lo_t;
			span_q   <= hi_t - lo_t;
			acc_q    <= '0;
		end else if (state_q == ST_MUL) begin
			wa_q <= {wa_q[BYTE_W-2:0], 1'b0};
			wb_q <= {wb_q[BYTE_W-2:0], 1'b0};
			if (cnt_q == 3'd7) begin
				acc_q <= num_full;
				// divisor 2*span aligned to the top quotient bit
				div_q <= ACC_W'({span_q, 1'b0}) << 7;
			end else begin
				acc_q <= mul_nxt;
			end
		end else if (state_q == ST_DIV) begin
			if (div_ge) begin
				acc_q <= acc_q - div_q;
			end
			target_q <= {target_q[BYTE_W-2:0], div_ge};
			div_q    <= div_q >> 1;
		end
		if (out_load) begin
			duty_out_q   <= duty_nxt;
			target_out_q <= target_q;
			changed_q    <= duty_nxt != present_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {target_out_q, duty_out_q};
	assign m_tuser  = changed_q;

endmodule

`default_nettype wire

// ===== dv/testbench.sv =====
// testbench for the fan curve block: curve settings and temperature samples checked against a fan model
`timescale 1ns / 100ps

module testbench;
	import fcr_pkg::*;

	localparam int CYCLE_LIMIT    = 400000;
	localparam int RANDOM_SAMPLES = 800;

	typedef struct packed {
		logic [7:0] duty;
		logic [7:0] target;
		logic       changed;
	} fan_result_t;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;
	logic                  s_tvalid  = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata   = '0;   // [7:0] temperature
	logic                  m_tvalid;
	logic                  m_tready  = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;          // [7:0] duty_out, [15:8] target_duty
	logic                  m_tuser;          // [0] duty_changed

	// curve settings and fan duty as the block should hold them
	logic [3:0]  curve_count;
	logic [63:0] curve_temps;
	logic [63:0] curve_duties;
	logic [7:0]  slew_step;
	logic [7:0]  fan_duty;

	logic [7:0]  temp_q[$];
	fan_result_t duty_q[$];
	int unsigned temps_queued = 0;
	int unsigned temps_taken  = 0;
	int unsigned fail_cnt     = 0;
	int unsigned cyc          = 0;
	int unsigned burst_left   = 0;
	int unsigned gap_left     = 0;
	int unsigned rx_tick      = 0;

	fan_curve_with_pwm_ramp dut (.*);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
	end

	function automatic logic [7:0] curve_lookup(input logic [7:0] t);
		int unsigned n, lo_t, hi_t, lo_d, hi_d, dt, span;
		n = curve_count;
		if (n < 2) n = 2;
		if (n > DEF_MAX_POINTS) n = DEF_MAX_POINTS;
		if (t >= curve_temps[8*(n-1) +: 8])
			return curve_duties[8*(n-1) +: 8];
		for (int i = int'(n) - 2; i >= 0; i--) begin
			lo_t = curve_temps[8*i +: 8];
			if (t >= lo_t) begin
				hi_t = curve_temps[8*(i+1) +: 8];
				lo_d = curve_duties[8*i +: 8];
				hi_d = curve_duties[8*(i+1) +: 8];
				// only reachable when the points are not in order
				if (hi_t <= t)
					return 8'(hi_d);
				dt   = t - lo_t;
				span = hi_t - lo_t;
				return 8'((2 * (lo_d * (span - dt) + hi_d * dt) + span) / (2 * span));
			end
		end
		return curve_duties[7:0];
	endfunction

	function automatic fan_result_t next_duty(input logic [7:0] t);
		fan_result_t r;
		int unsigned step, old, nxt, tgt;
		tgt  = curve_lookup(t);
		step = (slew_step == 0) ? 1 : slew_step;
		old  = fan_duty;
		nxt  = old;
		if (old < tgt) begin
			nxt = old + step;
			if (nxt > tgt) nxt = tgt;
		end else if (old > tgt) begin
			nxt = (old >= step) ? old - step : 0;
			if (nxt < tgt) nxt = tgt;
		end
		r.duty    = 8'(nxt);
		r.target  = 8'(tgt);
		r.changed = (nxt != old);
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			curve_count  <= POINT_COUNT_RST;
			curve_temps  <= '0;
			curve_duties <= '0;
			slew_step    <= RAMP_STEP_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (fcr_reg_t'(cfg_index))
				REG_POINT_COUNT: curve_count  <= cfg_data[3:0];
				REG_TEMP_POINTS: curve_temps  <= cfg_data;
				REG_DUTY_POINTS: curve_duties <= cfg_data;
				REG_RAMP_STEP:   slew_step    <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	always @(posedge clk or negedge arst_n) begin : sample_driver
		logic        show;
		fan_result_t res;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			fan_duty <= DUTY_RST;
		end else begin
			show = s_tvalid;
			if (s_tvalid && s_tready) begin
				res = next_duty(s_tdata);
				duty_q.push_back(res);
				fan_duty <= res.duty;
				temps_taken++;
				show = 1'b0;
			end
			if (!show) begin
				if (gap_left > 0) begin
					gap_left--;
				end else if (temp_q.size() > 0) begin
					s_tdata <= temp_q.pop_front();
					show = 1'b1;
					if (burst_left == 0) burst_left = $urandom_range(1, 16);
					burst_left--;
					if (burst_left == 0)
						gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
				end
			end
			s_tvalid <= show;
		end
	end

	always @(posedge clk or negedge arst_n) begin : result_monitor
		fan_result_t want;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (duty_q.size() == 0) begin
					$error("result with no sample waiting: tdata %h tuser %b", m_tdata, m_tuser);
					fail_cnt++;
				end else begin
					want = duty_q.pop_front();
					if (m_tdata[7:0] !== want.duty) begin
						$error("duty_out: expected %0d, got %0d", want.duty, m_tdata[7:0]);
						fail_cnt++;
					end
					if (m_tdata[15:8] !== want.target) begin
						$error("target_duty: expected %0d, got %0d", want.target, m_tdata[15:8]);
						fail_cnt++;
					end
					if (m_tuser !== want.changed) begin
						$error("duty_changed: expected %0d, got %0d", want.changed, m_tuser);
						fail_cnt++;
					end
				end
			end
			// stall pattern rotates between always ready, light, heavy and periodic
			rx_tick++;
			case (rx_tick[8:7])
				2'd0:    m_tready <= 1'b1;
				2'd1:    m_tready <= ($urandom_range(0, 3) != 0);
				2'd2:    m_tready <= ($urandom_range(0, 3) == 0);
				default: m_tready <= (rx_tick % 7) < 3;
			endcase
		end
	end

	always @(posedge clk) begin
		cyc++;
		if (cyc >= CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	function automatic logic [63:0] rand64();
		return {$urandom(), $urandom()};
	endfunction

	task automatic write_reg(input fcr_reg_t idx, input logic [63:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
	endtask

	// junk in the unused upper bits of the narrow registers
	task automatic program_curve(input logic [3:0] cnt, input logic [63:0] temps,
		input logic [63:0] duties, input logic [7:0] step, input logic [3:0] which);
		logic [63:0] junk;
		junk = rand64();
		if (which[0]) write_reg(REG_POINT_COUNT, {junk[63:4], cnt});
		if (which[1]) write_reg(REG_TEMP_POINTS, temps);
		if (which[2]) write_reg(REG_DUTY_POINTS, duties);
		if (which[3]) write_reg(REG_RAMP_STEP, {junk[63:8], step});
	endtask

	task automatic queue_temp(input logic [7:0] t);
		temp_q.push_back(t);
		temps_queued++;
	endtask

	task automatic drain();
		@(posedge clk);
		while (!(temps_taken == temps_queued && duty_q.size() == 0)) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	initial begin : stimulus
		int          placed;
		int          n;
		int          v;
		int          phase;
		logic [3:0]  cnt;
		logic [63:0] temps;
		logic [7:0]  step;
		logic [7:0]  curve_b[14];
		logic [7:0]  rev_b[6];

		curve_b = '{0, 10, 25, 39, 40, 41, 79, 80, 100, 200, 249, 250, 255, 1};
		rev_b   = '{8'h90, 8'h85, 8'h75, 8'h05, 8'h10, 8'h80};
		@(posedge arst_n);

		// reset settings: every point at zero
		queue_temp(8'd0);
		queue_temp(8'd255);
		drain();

		// full curve with a repeated point and the widest steps
		program_curve(4'd8, 64'hFA_C8_A0_78_50_28_28_0A, 64'hFF_C8_1E_FF_64_32_FF_00,
			8'd255, 4'hF);
		foreach (curve_b[i]) queue_temp(curve_b[i]);
		drain();

		// count above the maximum, zero step, points in falling order
		program_curve(4'd15, 64'h10_20_30_40_50_60_70_80, 64'h00_FF_10_F0_20_E0_30_D0,
			8'd0, 4'hF);
		foreach (rev_b[i]) queue_temp(rev_b[i]);
		drain();

		// count below the minimum
		program_curve(4'd1, 64'h0, 64'h0, 8'd1, 4'b0001);
		queue_temp(8'h77);
		drain();
		program_curve(4'd0, 64'h0, 64'h0, 8'd1, 4'b0001);
		queue_temp(8'h20);
		drain();

		placed = 0;
		phase  = 0;
		while (placed < RANDOM_SAMPLES) begin
			if (phase == 0) begin
				program_curve(4'd2, 64'h0000_0000_0000_FF00, 64'h0000_0000_0000_FF00,
					8'd1, 4'hF);
			end else if (phase == 1) begin
				program_curve(4'd8, '1, '0, 8'd255, 4'hF);
			end else begin
				cnt = ($urandom_range(0, 7) == 0) ? 4'($urandom_range(0, 15))
					: 4'($urandom_range(2, 8));
				if ($urandom_range(0, 3) == 0) begin
					temps = rand64();
				end else begin
					v = $urandom_range(0, 80);
					for (int k = 0; k < 8; k++) begin
						temps[8*k +: 8] = 8'(v);
						v += $urandom_range(0, 40);
						if (v > 255) v = 255;
					end
				end
				case ($urandom_range(0, 4))
					0:       step = 8'd0;
					1:       step = 8'd1;
					2:       step = 8'd255;
					default: step = 8'($urandom_range(1, 64));
				endcase
				program_curve(cnt, temps, rand64(), step,
					($urandom_range(0, 3) == 0) ? 4'($urandom()) : 4'hF);
			end
			n = $urandom_range(20, 80);
			for (int j = 0; j < n; j++) begin
				if ($urandom_range(0, 2) == 0) begin
					queue_temp(8'($urandom()));
				end else begin
					// land close to a curve point
					v = int'(curve_temps[8*$urandom_range(0, 7) +: 8])
						+ int'($urandom_range(0, 6)) - 3;
					if (v < 0) v = 0;
					if (v > 255) v = 255;
					queue_temp(8'(v));
				end
			end
			placed += n;
			phase++;
			drain();
		end

		repeat (40) @(posedge clk);
		if (fail_cnt == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/core/fcr_pkg.sv
rtl/core/fan_curve_with_pwm_ramp.sv
dv/testbench.sv
